### rtl/core/owsm_pkg.sv
// ----------------------------------------------------------------------------
// owsm_pkg - shared types and constants of the 1-wire slot master
// command codes, one-hot phase codes, pin modes and slot timings in ticks
// ----------------------------------------------------------------------------
package owsm_pkg;

  localparam int unsigned KindW  = 3;
  localparam int unsigned DataW  = 8;
  localparam int unsigned PinW   = 2;
  localparam int unsigned TimerW = 9;
  localparam int unsigned BitCntW = 4;

  // item kinds; codes 6 and 7 are no-op items
  typedef enum logic [KindW-1:0] {
    K_TICK  = 3'd0,
    K_RESET = 3'd1,
    K_WBIT  = 3'd2,
    K_RBIT  = 3'd3,
    K_WBYTE = 3'd4,
    K_RBYTE = 3'd5
  } kind_e;

  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_HIGH  = 5'b00010,
    PH_LOW   = 5'b00100,
    PH_REL   = 5'b01000,
    PH_RECOV = 5'b10000
  } phase_e;

  typedef enum logic [PinW-1:0] {
    PIN_REL  = 2'd0,
    PIN_LOW  = 2'd1,
    PIN_HIGH = 2'd2
  } pin_e;

  // phase lengths in 1 us ticks
  localparam logic [TimerW-1:0] T_HIGH        = 9'd5;
  localparam logic [TimerW-1:0] T_RST_LOW     = 9'd485;
  localparam logic [TimerW-1:0] T_RST_REL     = 9'd60;
  localparam logic [TimerW-1:0] T_RST_RECOV   = 9'd480;
  localparam logic [TimerW-1:0] T_W1_LOW      = 9'd10;
  localparam logic [TimerW-1:0] T_W0_LOW      = 9'd62;
  localparam logic [TimerW-1:0] T_W1_REL      = 9'd50;
  localparam logic [TimerW-1:0] T_RD_LOW      = 9'd2;
  localparam logic [TimerW-1:0] T_RD_REL      = 9'd15;
  localparam logic [TimerW-1:0] T_RD_RECOV    = 9'd45;

  localparam logic [BitCntW-1:0] BitsPerByte  = 4'd8;

endpackage

### rtl/core/owsm_in_if.sv
// ----------------------------------------------------------------------------
// owsm_in_if - command and tick channel
// valid/ready channel carrying one tick or command item
// ----------------------------------------------------------------------------
interface owsm_in_if;
  logic                        valid;
  logic                        ready;
  logic [owsm_pkg::KindW-1:0]  kind;
  logic [owsm_pkg::DataW-1:0]  data;
  logic                        bus_level;

  modport source (output valid, output kind, output data, output bus_level, input ready);
  modport sink   (input valid, input kind, input data, input bus_level, output ready);
endinterface

### rtl/core/owsm_out_if.sv
// ----------------------------------------------------------------------------
// owsm_out_if - result channel
// valid/ready channel carrying one status item per accepted input item
// ----------------------------------------------------------------------------
interface owsm_out_if;
  logic                        valid;
  logic                        ready;
  logic [owsm_pkg::PinW-1:0]   pin_mode;
  logic                        busy_res;
  logic                        done_res;
  logic [owsm_pkg::DataW-1:0]  result_value;
  logic                        rejected;

  modport source (output valid, output pin_mode, output busy_res, output done_res,
                  output result_value, output rejected, input ready);
  modport sink   (input valid, input pin_mode, input busy_res, input done_res,
                  input result_value, input rejected, output ready);
endinterface

### rtl/core/one_wire_slot_master.sv
// ----------------------------------------------------------------------------
// one_wire_slot_master - 1-wire bus master timed by 1 us tick items
// runs reset/presence, read-bit, write-bit and byte sequences, one status
// transaction out for every transaction in
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake     payload
//  -------  ---  ------------  -------------------------------------------
//  in_i     in   valid/ready   kind[2:0], data[7:0], bus_level
//  out_o    out  valid/ready   pin_mode[1:0], busy_res, done_res,
//                              result_value[7:0], rejected
//
//  one transaction per cycle while out_o.ready stays high; its status appears on out_o the next cycle
//  the phase state machine updates at accept and the status lands in the
//  output register at the same edge
//  in_i.ready is high while the output register is empty or being drained
//  rst_ni clears the sequence state and the output valid flag at once
//
module one_wire_slot_master (
  input  logic clk_i,
  input  logic rst_ni,
  owsm_in_if.sink    in_i,
  owsm_out_if.source out_o
);
  import owsm_pkg::*;

  // sequence state
  phase_e                phase_q, phase_d;
  logic [TimerW-1:0]     timer_q, timer_d;
  logic [BitCntW-1:0]    bit_cnt_q, bit_cnt_d;
  logic [DataW-1:0]      shift_q, shift_d;
  kind_e                 cmd_q, cmd_d;

  // status of the current item
  logic                  done;
  logic                  rej;
  logic [DataW-1:0]      result;
  pin_e                  pin;

  // output register
  logic                  out_valid_q;
  pin_e                  pin_q;
  logic                  busy_q;
  logic                  done_q;
  logic [DataW-1:0]      result_q;
  logic                  rej_q;

  logic                  accept;
  logic                  is_write;
  logic                  is_byte;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  assign is_write = (cmd_q == K_WBIT) || (cmd_q == K_WBYTE);
  assign is_byte  = (cmd_q == K_WBYTE) || (cmd_q == K_RBYTE);

  always_comb begin
    phase_d   = phase_q;
    timer_d   = timer_q;
    bit_cnt_d = bit_cnt_q;
    shift_d   = shift_q;
    cmd_d     = cmd_q;
    done      = 1'b0;
    rej       = 1'b0;

    case (in_i.kind)
      K_TICK: begin
        if (phase_q != PH_IDLE) begin
          if (timer_q > 9'd1) begin
            timer_d = timer_q - 9'd1;
          end else begin
            // phase expires on this tick
            case (phase_q)
              PH_HIGH: begin
                phase_d = PH_LOW;
                if (cmd_q == K_RESET) begin
                  timer_d = T_RST_LOW;
                end else if (is_write) begin
                  timer_d = shift_q[0] ? T_W1_LOW : T_W0_LOW;
                end else begin
                  timer_d = T_RD_LOW;
                end
              end
              PH_LOW: begin
                if (cmd_q == K_RESET) begin
                  phase_d = PH_REL;
                  timer_d = T_RST_REL;
                end else if (is_write && shift_q[0]) begin
                  phase_d = PH_REL;
                  timer_d = T_W1_REL;
                end else if (is_write) begin
                  // write zero ends the slot at the end of the low time
                  done = 1'b1;
                end else begin
                  phase_d = PH_REL;
                  timer_d = T_RD_REL;
                end
              end
              PH_REL: begin
                if (cmd_q == K_RESET) begin
                  // line low at the sample point means a device is present
                  shift_d = {{(DataW-1){1'b0}}, !in_i.bus_level};
                  phase_d = PH_RECOV;
                  timer_d = T_RST_RECOV;
                end else if (is_write) begin
                  done = 1'b1;
                end else begin
                  if (cmd_q == K_RBYTE) begin
                    shift_d = {in_i.bus_level, shift_q[DataW-1:1]};
                  end else begin
                    shift_d = {{(DataW-1){1'b0}}, in_i.bus_level};
                  end
                  phase_d = PH_RECOV;
                  timer_d = T_RD_RECOV;
                end
              end
              PH_RECOV: begin
                done = 1'b1;
              end
              default: begin
                phase_d   = PH_IDLE;
                timer_d   = '0;
                bit_cnt_d = '0;
              end
            endcase

            // end of slot: next bit of a byte, or finish the command
            if (done) begin
              if (is_byte) begin
                if (cmd_q == K_WBYTE) begin
                  shift_d = shift_q >> 1;
                end
                bit_cnt_d = bit_cnt_q + 4'd1;
              end
              if (is_byte && (bit_cnt_d < BitsPerByte)) begin
                done    = 1'b0;
                phase_d = PH_HIGH;
                timer_d = T_HIGH;
              end else begin
                phase_d   = PH_IDLE;
                timer_d   = '0;
                bit_cnt_d = '0;
              end
            end
          end
        end
      end
      K_RESET, K_WBIT, K_RBIT, K_WBYTE, K_RBYTE: begin
        if (phase_q != PH_IDLE) begin
          rej = 1'b1;
        end else begin
          cmd_d     = kind_e'(in_i.kind);
          bit_cnt_d = '0;
          if (in_i.kind == K_WBIT) begin
            shift_d = {{(DataW-1){1'b0}}, (in_i.data != '0)};
          end else if (in_i.kind == K_WBYTE) begin
            shift_d = in_i.data;
          end else begin
            shift_d = '0;
          end
          phase_d = PH_HIGH;
          timer_d = T_HIGH;
        end
      end
      default: begin
        // unused kinds: report status, no time advance
      end
    endcase
  end

  // read commands report the sampled value, reset reports presence, writes report zero
  assign result = (done && !is_write) ? shift_d : '0;

  always_comb begin
    case (phase_d)
      PH_HIGH: pin = PIN_HIGH;
      PH_LOW:  pin = PIN_LOW;
      default: pin = PIN_REL;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      timer_q   <= '0;
      bit_cnt_q <= '0;
      shift_q   <= '0;
      cmd_q     <= K_TICK;
    end else if (accept) begin
      phase_q   <= phase_d;
      timer_q   <= timer_d;
      bit_cnt_q <= bit_cnt_d;
      shift_q   <= shift_d;
      cmd_q     <= cmd_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // status payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pin_q    <= pin;
      busy_q   <= (phase_d != PH_IDLE);
      done_q   <= done;
      result_q <= result;
      rej_q    <= rej;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.pin_mode     = pin_q;
  assign out_o.busy_res     = busy_q;
  assign out_o.done_res     = done_q;
  assign out_o.result_value = result_q;
  assign out_o.rejected     = rej_q;

  // a finished command leaves the block idle
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.done_res |-> !out_o.busy_res)
    else $error("done reported while still busy");

  // a rejected command never finishes anything and only happens while busy
  a_reject_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.rejected |-> out_o.busy_res && !out_o.done_res)
    else $error("reject reported while idle or with done");

  // a command accepted while idle starts with the line driven high
  a_cmd_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (phase_q == PH_IDLE) &&
    ((in_i.kind == K_RESET) || (in_i.kind == K_WBIT) || (in_i.kind == K_RBIT) ||
     (in_i.kind == K_WBYTE) || (in_i.kind == K_RBYTE))
    |=> out_o.valid && out_o.busy_res && (out_o.pin_mode == PIN_HIGH))
    else $error("command did not start a high phase");

  // the bus is released whenever the block reports idle
  a_idle_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.busy_res |-> (out_o.pin_mode == PIN_REL))
    else $error("pin driven while idle");

endmodule

### bench/one_wire_slot_master_tb.sv
// ----------------------------------------------------------------------------
// one_wire_slot_master_tb - self-checking bench for the 1-wire slot master
// walks a directed table of bit slots, rejects and no-ops, then random
// items with noise under four idling patterns; every status transaction is
// compared field by field with a typed row or a cycle-free slot predictor
// ----------------------------------------------------------------------------
module one_wire_slot_master_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import owsm_pkg::*;

  // kinds outside the command set, accepted and reported as no-ops
  localparam logic [KindW-1:0] KindNop6 = 3'd6;
  localparam logic [KindW-1:0] KindNop7 = 3'd7;

  // cycles with no transaction on either channel before the run is called dead
  localparam int unsigned QuietLimit = 2000;
  // settle time after the last status
  localparam int unsigned DrainCycles = 16;
  // random items sent under each idling pattern
  localparam int unsigned ItemsPerPhase = 32;

  typedef struct packed {
    pin_e             pin;
    logic             busy;
    logic             done_flag;
    logic [DataW-1:0] value;
    logic             rej;
  } status_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [DataW-1:0] data;
    logic             level;
    logic [10:0]      reps;
    logic             typed;
    status_t          want;
  } dir_row_t;

  localparam status_t StIdle  = '{PIN_REL, 1'b0, 1'b0, 8'h00, 1'b0};
  localparam status_t StStart = '{PIN_HIGH, 1'b1, 1'b0, 8'h00, 1'b0};
  localparam status_t StRej   = '{PIN_HIGH, 1'b1, 1'b0, 8'h00, 1'b1};

  // directed table: rows with typed set carry an expectation read off the
  // slot timing rules; the tick runs are checked by the predictor
  localparam int NumDirRows = 14;
  localparam dir_row_t DirRows [NumDirRows] = '{
    '{K_TICK,   8'h00, 1'b0, 11'd1,  1'b1, StIdle},   // tick while idle
    '{KindNop6, 8'hFF, 1'b1, 11'd1,  1'b1, StIdle},   // no-op while idle
    '{K_WBIT,   8'h00, 1'b0, 11'd1,  1'b1, StStart},  // write zero
    '{K_RBIT,   8'h00, 1'b0, 11'd1,  1'b1, StRej},    // command while busy
    '{KindNop7, 8'h00, 1'b0, 11'd1,  1'b1, StStart},  // no-op while busy
    '{K_TICK,   8'h00, 1'b0, 11'd68, 1'b0, StIdle},
    '{K_WBIT,   8'h80, 1'b0, 11'd1,  1'b1, StStart},  // nonzero data writes a one
    '{K_WBYTE,  8'hFF, 1'b0, 11'd1,  1'b1, StRej},
    '{K_TICK,   8'h00, 1'b0, 11'd66, 1'b0, StIdle},
    '{K_RBIT,   8'h00, 1'b0, 11'd1,  1'b1, StStart},
    '{K_TICK,   8'h00, 1'b0, 11'd68, 1'b0, StIdle},   // reads a zero
    '{K_RBIT,   8'h00, 1'b1, 11'd1,  1'b1, StStart},
    '{K_RESET,  8'h00, 1'b0, 11'd1,  1'b1, StRej},
    '{K_TICK,   8'h00, 1'b1, 11'd68, 1'b0, StIdle}    // reads a one
  };

  localparam int unsigned SrcIdle  [4] = '{0, 88, 0, 25};
  localparam int unsigned SnkStall [4] = '{0, 0, 88, 25};

  logic clk_i;
  logic rst_ni;

  owsm_in_if  in_if ();
  owsm_out_if out_if ();

  one_wire_slot_master dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // slot predictor state
  phase_e             slot_phase = PH_IDLE;
  logic [TimerW-1:0]  slot_timer = '0;
  logic [BitCntW-1:0] slot_bits  = '0;
  logic [DataW-1:0]   slot_shift = '0;
  kind_e              slot_cmd   = K_TICK;

  status_t     pending_status [$];
  int unsigned fail_count    = 0;
  int unsigned src_idle_pct  = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned quiet_cycles  = 0;

  function automatic bit slot_writes();
    return slot_cmd == K_WBIT || slot_cmd == K_WBYTE;
  endfunction

  // end of one slot or of the reset sequence; byte commands loop for 8 slots
  function automatic bit close_slot();
    if (slot_cmd == K_WBYTE || slot_cmd == K_RBYTE) begin
      if (slot_cmd == K_WBYTE) slot_shift = slot_shift >> 1;
      slot_bits = slot_bits + 1'b1;
      if (slot_bits < BitsPerByte) begin
        slot_phase = PH_HIGH;
        slot_timer = T_HIGH;
        return 1'b0;
      end
    end
    slot_phase = PH_IDLE;
    slot_timer = '0;
    slot_bits  = '0;
    return 1'b1;
  endfunction

  // phase expiry on a tick; returns one when the command completes
  function automatic bit expire_phase(input logic level);
    case (slot_phase)
      PH_HIGH: begin
        slot_phase = PH_LOW;
        if (slot_cmd == K_RESET) slot_timer = T_RST_LOW;
        else if (slot_writes()) slot_timer = slot_shift[0] ? T_W1_LOW : T_W0_LOW;
        else slot_timer = T_RD_LOW;
        return 1'b0;
      end
      PH_LOW: begin
        if (slot_writes() && !slot_shift[0]) return close_slot();
        slot_phase = PH_REL;
        if (slot_cmd == K_RESET) slot_timer = T_RST_REL;
        else if (slot_writes()) slot_timer = T_W1_REL;
        else slot_timer = T_RD_REL;
        return 1'b0;
      end
      PH_REL: begin
        if (slot_writes()) return close_slot();
        // sampling tick: presence is a low line, reads shift in LSB first
        if (slot_cmd == K_RESET) begin
          slot_shift = {7'd0, ~level};
          slot_timer = T_RST_RECOV;
        end else begin
          if (slot_cmd == K_RBYTE) slot_shift = {level, slot_shift[DataW-1:1]};
          else slot_shift = {7'd0, level};
          slot_timer = T_RD_RECOV;
        end
        slot_phase = PH_RECOV;
        return 1'b0;
      end
      PH_RECOV: return close_slot();
      default: begin
        slot_phase = PH_IDLE;
        slot_timer = '0;
        slot_bits  = '0;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic status_t next_bus_status(input logic [KindW-1:0] kind,
                                              input logic [DataW-1:0] data,
                                              input logic level);
    status_t st;
    st = StIdle;
    if (kind == K_TICK) begin
      if (slot_phase != PH_IDLE) begin
        if (slot_timer <= 1) begin
          if (expire_phase(level)) begin
            st.done_flag = 1'b1;
            st.value     = slot_writes() ? 8'h00 : slot_shift;
          end
        end else begin
          slot_timer = slot_timer - 1'b1;
        end
      end
    end else if (kind <= K_RBYTE) begin
      if (slot_phase != PH_IDLE) begin
        st.rej = 1'b1;
      end else begin
        slot_cmd  = kind_e'(kind);
        slot_bits = '0;
        if (kind == K_WBIT) slot_shift = {7'd0, data != 8'h00};
        else if (kind == K_WBYTE) slot_shift = data;
        else slot_shift = '0;
        slot_phase = PH_HIGH;
        slot_timer = T_HIGH;
      end
    end
    // no-op kinds leave the state alone
    case (slot_phase)
      PH_HIGH: st.pin = PIN_HIGH;
      PH_LOW:  st.pin = PIN_LOW;
      default: st.pin = PIN_REL;
    endcase
    st.busy = slot_phase != PH_IDLE;
    return st;
  endfunction

  // offer one item, wait for its transaction, then log what it must produce
  task automatic send_item(input logic [KindW-1:0] kind, input logic [DataW-1:0] data,
                           input logic level, input logic typed, input status_t want);
    status_t predicted;
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.kind      <= kind;
    in_if.data      <= data;
    in_if.bus_level <= level;
    do @(posedge clk_i); while (!in_if.ready);
    predicted = next_bus_status(kind, data, level);
    pending_status.push_back(typed ? want : predicted);
  endtask

  // random items: a bit command or a stray tick or no-op while idle,
  // ticks with the odd rejected command or no-op while busy
  task automatic run_items(input int unsigned count);
    logic [KindW-1:0] kind;
    logic [DataW-1:0] data;
    int unsigned      pick;
    for (int unsigned n = 0; n < count; n++) begin
      data = 8'($urandom);
      if (slot_phase == PH_IDLE) begin
        pick = $urandom_range(9);
        if (pick == 0) kind = KindNop6;
        else if (pick == 1) kind = K_TICK;
        else if (pick <= 5) kind = K_WBIT;
        else kind = K_RBIT;
        if (kind == K_WBIT && $urandom_range(1) == 0) data = 8'h00;
      end else if ($urandom_range(19) == 0) begin
        kind = 3'($urandom_range(1, 7));
      end else begin
        kind = K_TICK;
      end
      send_item(kind, data, 1'($urandom), 1'b0, StIdle);
    end
  endtask

  // status side: random backpressure and field-by-field compare
  always @(posedge clk_i) begin
    if (out_if.valid && out_if.ready) begin
      if (pending_status.size() == 0) begin
        $error("status transaction with nothing expected");
        fail_count++;
      end else begin
        status_t want;
        want = pending_status.pop_front();
        if (out_if.pin_mode !== want.pin) begin
          $error("pin_mode: expected %0d, got %0d", want.pin, out_if.pin_mode);
          fail_count++;
        end
        if (out_if.busy_res !== want.busy) begin
          $error("busy_res: expected %0d, got %0d", want.busy, out_if.busy_res);
          fail_count++;
        end
        if (out_if.done_res !== want.done_flag) begin
          $error("done_res: expected %0d, got %0d", want.done_flag, out_if.done_res);
          fail_count++;
        end
        if (out_if.result_value !== want.value) begin
          $error("result_value: expected %02h, got %02h", want.value, out_if.result_value);
          fail_count++;
        end
        if (out_if.rejected !== want.rej) begin
          $error("rejected: expected %0d, got %0d", want.rej, out_if.rejected);
          fail_count++;
        end
      end
    end
    out_if.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // watchdog on channel activity
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst_ni          <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.kind      <= K_TICK;
    in_if.data      <= '0;
    in_if.bus_level <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table, no idling
    for (int r = 0; r < NumDirRows; r++) begin
      for (int n = 0; n < DirRows[r].reps; n++)
        send_item(DirRows[r].kind, DirRows[r].data, DirRows[r].level,
                  DirRows[r].typed, DirRows[r].want);
    end

    // random items under each idling pattern
    for (int p = 0; p < 4; p++) begin
      src_idle_pct  = SrcIdle[p];
      snk_stall_pct = SnkStall[p];
      run_items(ItemsPerPhase);
    end

    in_if.valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

### filelist.f
rtl/core/owsm_pkg.sv
rtl/core/owsm_in_if.sv
rtl/core/owsm_out_if.sv
rtl/core/one_wire_slot_master.sv
bench/one_wire_slot_master_tb.sv
